// ===== hdl/key_checksum_validator_assert.svh =====
// ----------------------------------------------------------------------------
// key_checksum_validator_assert.svh
// Assertion macros for the key checksum validator RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_CHECKSUM_VALIDATOR_ASSERT_SVH
`define KEY_CHECKSUM_VALIDATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define KCV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define KCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kcv_pkg.sv =====
// ----------------------------------------------------------------------------
// kcv_pkg
// Types, alphabet table and helper functions for the key checksum validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcv_pkg;

  localparam int LEN_W  = 3;
  localparam int SUM_W  = 5;
  localparam int BYTE_W = 8;
  localparam int SYM_N  = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = 3'd4;
  localparam logic [LEN_W-1:0] COUNT_MAX = 3'd7;

  // 32-symbol alphabet, index order
  localparam logic [BYTE_W-1:0] SYM_TABLE [SYM_N] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
    8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4D, 8'h4E, 8'h50, 8'h51,
    8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
  };

  // Per-cell window control
  typedef struct packed {
    logic shift;    // take neighbor byte
    logic clear;    // end of key: zero the cell
    logic capture;  // end of key: snapshot incoming byte for the verdict
  } cell_ctl_t;

  // Verdict context shared by all cells
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SUM_W-1:0] sum;
  } verd_ctx_t;

  // Accumulator result for the current beat
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             short_key;
  } acc_stat_t;

  // Byte to alphabet index, 0 when absent
  function automatic logic [SUM_W-1:0] sym_index(input logic [BYTE_W-1:0] b);
    logic [SUM_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < SYM_N; k++) begin
      if (SYM_TABLE[k] == b) begin
        idx = SUM_W'(k);
      end
    end
    return idx;
  endfunction

  // Alphabet symbol at an index
  function automatic logic [BYTE_W-1:0] sym_at(input logic [SUM_W-1:0] idx);
    return SYM_TABLE[idx];
  endfunction

endpackage

// ===== hdl/kcv_in_if.sv =====
// ----------------------------------------------------------------------------
// kcv_in_if
// Key byte stream channel: one key byte and last flag per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_char;
  logic       is_last;

  modport source (output valid, output key_char, output is_last, input ready);
  modport sink   (input valid, input key_char, input is_last, output ready);
endinterface

// ===== hdl/kcv_out_if.sv =====
// ----------------------------------------------------------------------------
// kcv_out_if
// Verdict channel: one verdict beat per key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kcv_out_if;
  logic valid;
  logic ready;
  logic key_valid;
  logic too_short;

  modport source (output valid, output key_valid, output too_short, input ready);
  modport sink   (input valid, input key_valid, input too_short, output ready);
endinterface

// ===== hdl/kcv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kcv_cfg_if
// Configuration write channel carrying the checksum length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kcv_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] check_length;

  modport source (output valid, output check_length, input ready);
  modport sink   (input valid, input check_length, output ready);
endinterface

// ===== hdl/kcv_cell.sv =====
// ----------------------------------------------------------------------------
// kcv_cell
// One window cell: holds a key byte, passes it on, and checks its snapshot
// against the expected checksum symbol for its position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcv_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  kcv_pkg::cell_ctl_t            ctl,
  input  logic [kcv_pkg::BYTE_W-1:0]    byte_in,
  output logic [kcv_pkg::BYTE_W-1:0]    byte_out,
  input  kcv_pkg::verd_ctx_t            ctx,
  output logic                          match
);

  logic [kcv_pkg::BYTE_W-1:0] byte_r;
  logic [kcv_pkg::BYTE_W-1:0] byte_nxt;
  logic [kcv_pkg::BYTE_W-1:0] snap_r;
  logic [kcv_pkg::SUM_W-1:0]  pos;
  logic                       active;

  // window byte: clear at end of key, else shift
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = '0;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (ctl.capture) begin
      snap_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // checksum position i = len-1-cell, symbol at (sum - i) mod 32
  assign active = kcv_pkg::LEN_W'(CELL_IDX) < ctx.len;
  assign pos    = ctx.sum + kcv_pkg::SUM_W'(CELL_IDX) + 5'd1
                - {2'b00, ctx.len};
  assign match  = !active || (snap_r == kcv_pkg::sym_at(pos));

endmodule

// ===== hdl/kcv_accum.sv =====
// ----------------------------------------------------------------------------
// kcv_accum
// Running checksum sum, data parity and byte count for the key in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcv_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic                       last,
  input  logic [kcv_pkg::LEN_W-1:0]  len,
  input  logic [kcv_pkg::BYTE_W-1:0] ch,
  input  logic [kcv_pkg::BYTE_W-1:0] tap,
  output kcv_pkg::acc_stat_t         stat
);

  logic [kcv_pkg::SUM_W-1:0]  sum_r, sum_nxt, sum_new;
  logic                       parity_r, parity_nxt;
  logic [kcv_pkg::LEN_W-1:0]  count_r, count_nxt, count_new;
  logic                       have_data;
  logic [kcv_pkg::BYTE_W-1:0] data_byte;
  logic [kcv_pkg::SUM_W-1:0]  idx, weighted;

  // a byte leaves the window into the data part
  assign have_data = (len == '0) || (count_r >= len);
  assign data_byte = (len == '0) ? ch : tap;
  assign idx       = kcv_pkg::sym_index(data_byte);
  assign weighted  = parity_r ? idx : {idx[kcv_pkg::SUM_W-2:0], 1'b0};
  assign sum_new   = have_data ? (sum_r + weighted) : sum_r;
  assign count_new = (count_r == kcv_pkg::COUNT_MAX) ? count_r : count_r + 3'd1;

  // next state: clear after the last byte
  always_comb begin
    sum_nxt    = sum_r;
    parity_nxt = parity_r;
    count_nxt  = count_r;
    if (fire) begin
      if (last) begin
        sum_nxt    = '0;
        parity_nxt = 1'b0;
        count_nxt  = '0;
      end else begin
        sum_nxt    = sum_new;
        parity_nxt = parity_r ^ have_data;
        count_nxt  = count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      parity_r <= 1'b0;
      count_r  <= '0;
    end else begin
      sum_r    <= sum_nxt;
      parity_r <= parity_nxt;
      count_r  <= count_nxt;
    end
  end

  assign stat.sum       = sum_new;
  assign stat.short_key = count_new < len;

endmodule

// ===== hdl/key_checksum_validator.sv =====
// Throughput: one key byte per cycle, keys back to back, unless a verdict waits
//   on a stalled output; set by the window shift and the single-step sum update.
// Output: registered verdict stage behind a snapshot stage, taken while stalled.
// Reset: synchronous, active low; clears sum, count, parity and stage valids,
//   check_length returns to 4. No clearing pass.
// ----------------------------------------------------------------------------
// key_checksum_validator
// Streams key bytes through a row of window cells and gives a checksum
// verdict at the end of each key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "key_checksum_validator_assert.svh"

module key_checksum_validator #(
  parameter int MAX_CHECK_LEN = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  kcv_in_if.sink      in_bus,
  kcv_out_if.source   out_bus,
  kcv_cfg_if.sink     cfg_bus
);

  localparam int IDX_W = (MAX_CHECK_LEN > 1) ? $clog2(MAX_CHECK_LEN) : 1;

  logic [kcv_pkg::LEN_W-1:0]  check_len_r;
  logic [kcv_pkg::LEN_W-1:0]  len;
  logic [kcv_pkg::LEN_W-1:0]  len_m1;
  logic                       in_fire;
  logic                       in_last;
  kcv_pkg::cell_ctl_t         ctl;
  kcv_pkg::verd_ctx_t         snap_ctx_r;
  kcv_pkg::acc_stat_t         stat;
  logic                       snap_v_r, snap_v_nxt;
  logic                       snap_short_r;
  logic                       move;
  logic                       out_v_r, out_v_nxt;
  logic                       out_key_valid_r;
  logic                       out_too_short_r;
  logic [kcv_pkg::BYTE_W-1:0] win   [MAX_CHECK_LEN];
  logic [MAX_CHECK_LEN-1:0]   match;
  logic [kcv_pkg::BYTE_W-1:0] tap;

  // configuration register, writes always taken
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_len_r <= kcv_pkg::LEN_RESET;
    end else if (cfg_bus.valid) begin
      check_len_r <= cfg_bus.check_length;
    end
  end

  assign len = (check_len_r > kcv_pkg::LEN_W'(MAX_CHECK_LEN))
             ? kcv_pkg::LEN_W'(MAX_CHECK_LEN) : check_len_r;

  // input handshake
  assign move         = snap_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !snap_v_r || move;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign in_last      = in_fire && in_bus.is_last;

  assign ctl.shift   = in_fire;
  assign ctl.clear   = in_last;
  assign ctl.capture = in_last;

  // row of window cells, newest in cell 0
  for (genvar j = 0; j < MAX_CHECK_LEN; j++) begin : g_cell
    logic [kcv_pkg::BYTE_W-1:0] nb_in;
    if (j == 0) begin : g_head
      assign nb_in = in_bus.key_char;
    end else begin : g_body
      assign nb_in = win[j-1];
    end
    kcv_cell #(.CELL_IDX(j)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .byte_in  (nb_in),
      .byte_out (win[j]),
      .ctx      (snap_ctx_r),
      .match    (match[j])
    );
  end

  // oldest window byte within the checksum length
  assign len_m1 = len - 3'd1;
  assign tap    = win[len_m1[IDX_W-1:0]];

  kcv_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .last  (in_last),
    .len   (len),
    .ch    (in_bus.key_char),
    .tap   (tap),
    .stat  (stat)
  );

  // snapshot stage: sum, length and short flag at end of key
  always_comb begin
    snap_v_nxt = snap_v_r;
    if (in_last) begin
      snap_v_nxt = 1'b1;
    end else if (move) begin
      snap_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
    end
    if (in_last) begin
      snap_ctx_r.len <= len;
      snap_ctx_r.sum <= stat.sum;
      snap_short_r   <= stat.short_key;
    end
  end

  // verdict output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (move) begin
      out_v_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
    if (move) begin
      out_key_valid_r <= !snap_short_r && (&match);
      out_too_short_r <= snap_short_r;
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.key_valid = out_key_valid_r;
  assign out_bus.too_short = out_too_short_r;

  // checks
  `KCV_ASSERT_NOW(a_short_not_valid, out_v_r, !(out_key_valid_r && out_too_short_r), "short key reported valid")
  `KCV_ASSERT_NEXT(a_last_snaps, in_last, snap_v_r, "end of key not captured")
  `KCV_ASSERT_NEXT(a_snap_holds, snap_v_r && !move, snap_v_r && $stable(snap_ctx_r), "pending verdict lost")

endmodule

// ===== verif/kcv_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// kcv_verdict_checker
// Watches the key byte, verdict and config channels, predicts one verdict
// per finished key and compares each verdict beat against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcv_verdict_checker (
  input  logic clk,
  input  logic rst_n,
  kcv_in_if    in_mon,
  kcv_out_if   out_mon,
  kcv_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic key_valid;
    logic too_short;
  } verdict_t;

  verdict_t   expected_verdicts[$];
  int         mismatches  = 0;
  int         outstanding = 0;

  // Predicted block state
  logic [2:0] chk_len;
  logic [7:0] win [7];      // newest byte in entry 0
  logic [2:0] seen_cnt;     // saturates at seven
  logic [4:0] sum;
  logic       odd_pos;      // next data byte sits at an odd position

  assign fail_count = mismatches;
  assign pending    = outstanding;

  // Alphabet position of a byte, zero when the byte is not a symbol
  function automatic logic [4:0] alpha_pos(input logic [7:0] b);
    for (int k = 0; k < kcv_pkg::SYM_N; k++) begin
      if (kcv_pkg::SYM_TABLE[k] == b) return 5'(k);
    end
    return '0;
  endfunction

  task automatic start_new_key();
    for (int k = 0; k < 7; k++) win[k] = '0;
    seen_cnt = '0;
    sum      = '0;
    odd_pos  = 1'b0;
  endtask

  // One key byte: retire the byte leaving the window into the sum, shift,
  // and on the last byte work out the verdict
  task automatic absorb_key_byte(input logic [7:0] ch, input logic last);
    logic       take;
    logic [7:0] data_b;
    logic [4:0] v;
    logic       shrt;
    logic       good;
    verdict_t   vd;
    take   = 1'b0;
    data_b = '0;
    if (chk_len == 0) begin
      take   = 1'b1;
      data_b = ch;
    end else if (seen_cnt >= chk_len) begin
      take   = 1'b1;
      data_b = win[chk_len - 1];
    end
    if (take) begin
      v = alpha_pos(data_b);
      if (!odd_pos) v = v << 1;   // doubling mod 32
      sum     = sum + v;
      odd_pos = ~odd_pos;
    end
    for (int k = 6; k > 0; k--) win[k] = win[k-1];
    win[0] = ch;
    if (seen_cnt != 3'd7) seen_cnt = seen_cnt + 3'd1;
    if (last) begin
      shrt = seen_cnt < chk_len;
      good = !shrt;
      if (good) begin
        for (int i = 0; i < chk_len; i++) begin
          // sum + 31*i mod 32 is sum - i
          if (win[chk_len - 1 - i] != kcv_pkg::SYM_TABLE[5'(int'(sum) - i)]) good = 1'b0;
        end
      end
      vd.key_valid = good;
      vd.too_short = shrt;
      expected_verdicts.push_back(vd);
      start_new_key();
    end
  endtask

  // Verdicts are checked before new key bytes are taken in the same cycle
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      chk_len = kcv_pkg::LEN_RESET;
      start_new_key();
      expected_verdicts.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: verdict beat with none expected: key_valid %0b too_short %0b",
                   $time, out_mon.key_valid, out_mon.too_short);
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (out_mon.key_valid !== exp_v.key_valid) begin
            mismatches++;
            $display("%0t: key_valid expected %0b actual %0b",
                     $time, exp_v.key_valid, out_mon.key_valid);
          end
          if (out_mon.too_short !== exp_v.too_short) begin
            mismatches++;
            $display("%0t: too_short expected %0b actual %0b",
                     $time, exp_v.too_short, out_mon.too_short);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) chk_len = cfg_mon.check_length;
      if (in_mon.valid && in_mon.ready) absorb_key_byte(in_mon.key_char, in_mon.is_last);
    end
    outstanding <= expected_verdicts.size();
  end

endmodule

// ===== verif/key_checksum_validator_tb.sv =====
// ----------------------------------------------------------------------------
// key_checksum_validator_tb
// Drives keys byte by byte into the validator: a few hand-built keys, then
// phases of random keys (mostly with correct checksums, some corrupted, some
// raw noise) under several check lengths and idle patterns, including a long
// verdict stall. Checking is done by kcv_verdict_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_checksum_validator_tb;

  localparam int DRAIN_SLACK = 4;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_BEATS = 180;
  localparam logic [2:0] PHASE_LEN [6] = '{3'd2, 3'd7, 3'd0, 3'd1, 3'd5, 3'd3};
  localparam logic [7:0] NON_ALPHA [4] = '{8'h49, 8'h4C, 8'h4F, 8'h55};

  logic clk;
  logic rst_n;

  kcv_in_if  in_bus ();
  kcv_out_if out_bus ();
  kcv_cfg_if cfg_bus ();

  int   fail_count;
  int   pending;
  int   send_gap_pct;
  int   recv_gap_pct;
  bit   hold_req;
  int   beats_sent;

  // Key under construction and its running checksum
  logic [2:0] cur_len;
  logic [7:0] key_buf[$];
  logic [4:0] key_sum;
  logic       key_odd;

  key_checksum_validator #(.MAX_CHECK_LEN(7)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  kcv_verdict_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Verdict receiver: random ready, one long hold-off on request
  initial begin : verdict_sink
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] foreign_byte();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(8'h2F));
      1:       return 8'($urandom_range(255, 128));
      default: return NON_ALPHA[$urandom_range(3)];
    endcase
  endfunction

  // One beat on the key channel, with random gaps ahead of it
  task automatic send_beat(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.key_char <= ch;
    in_bus.is_last  <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_key();
    for (int i = 0; i < key_buf.size(); i++) send_beat(key_buf[i], i == key_buf.size() - 1);
    key_buf.delete();
    key_sum = '0;
    key_odd = 1'b0;
  endtask

  task automatic put_sym(input int idx);
    key_buf.push_back(kcv_pkg::SYM_TABLE[idx]);
    key_sum = key_sum + (key_odd ? 5'(idx) : 5'(idx * 2));
    key_odd = ~key_odd;
  endtask

  // Data byte outside the alphabet: adds zero but still takes a position
  task automatic put_foreign(input logic [7:0] b);
    key_buf.push_back(b);
    key_odd = ~key_odd;
  endtask

  task automatic put_checksum(input int n);
    for (int i = 0; i < n; i++) key_buf.push_back(kcv_pkg::SYM_TABLE[5'(int'(key_sum) - i)]);
  endtask

  // Mostly well-formed keys, some with a bad check byte, some raw noise
  task automatic random_key();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 85) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 85) put_sym($urandom_range(31));
        else put_foreign(foreign_byte());
      end
      if (cur_len == 0 && n == 0) put_sym($urandom_range(31));
      put_checksum(cur_len);
      if (kind >= 70 && cur_len != 0)
        key_buf[key_buf.size() - 1 - $urandom_range(cur_len - 1)] = 8'($urandom);
    end else begin
      n = $urandom_range(10, 1);
      repeat (n) key_buf.push_back(8'($urandom));
    end
    send_key();
  endtask

  // Wait until every verdict is in and the pipeline has settled
  task automatic drain_verdicts();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_check_len(input logic [2:0] v);
    drain_verdicts();
    cfg_bus.valid        <= 1'b1;
    cfg_bus.check_length <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    cur_len = v;
  endtask

  initial begin : stimulus
    int phase_start;
    in_bus.valid         <= 1'b0;
    in_bus.key_char      <= '0;
    in_bus.is_last       <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.check_length <= '0;
    rst_n                <= 1'b0;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_req     = 1'b0;
    beats_sent   = 0;
    cur_len      = kcv_pkg::LEN_RESET;
    key_buf.delete();
    key_sum      = '0;
    key_odd      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset length: good key with the alphabet's first and last symbols
    put_sym(0);
    put_sym(31);
    put_checksum(cur_len);
    send_key();
    // Foreign bytes 0xFF and 0x00 count as zero; first check byte wrong
    put_foreign(8'hFF);
    put_foreign(8'h00);
    put_checksum(cur_len);
    key_buf[key_buf.size() - cur_len] ^= 8'h01;
    send_key();
    // Key shorter than the check length
    put_sym(1);
    put_foreign(8'h49);
    send_key();
    // Zero check length: all bytes are data, always valid
    write_check_len(3'd0);
    put_sym(31);
    put_foreign(8'h7F);
    put_sym(10);
    send_key();
    // Longest check, no data at all
    write_check_len(3'd7);
    put_checksum(cur_len);
    send_key();
    // Single check byte key
    write_check_len(3'd1);
    put_checksum(cur_len);
    send_key();

    // Random phases over lengths and idle patterns
    for (int p = 0; p < 6; p++) begin
      write_check_len(PHASE_LEN[p]);
      case (p % 3)
        0: begin
          send_gap_pct = 34;
          recv_gap_pct = 50;
        end
        1: begin
          send_gap_pct = 50;
          recv_gap_pct = 34;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      // stall verdicts while keys keep coming, to back up the input
      if (p == 2) hold_req = 1'b1;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) random_key();
    end

    drain_verdicts();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
